// ===== rtl/met_pkg.sv =====
package met_pkg;

    localparam int TICK_W    = 32;
    localparam int TEMPO_W   = 24;
    localparam int PPQ_W     = 16;
    localparam int TIME_W    = 64;
    localparam int PROD_W    = TICK_W + TEMPO_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd500000;
    localparam logic [PPQ_W-1:0]   PPQ_RESET   = 16'd480;
    localparam logic [7:0]         META_TEMPO  = 8'h51;
    localparam logic [15:0]        TEMPO_MIN_EXTRA = 16'd3;

    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_POLY_PRESS = 4'hA;
    localparam logic [3:0] KIND_CONTROL    = 4'hB;
    localparam logic [3:0] KIND_PROGRAM    = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
    localparam logic [3:0] KIND_PITCH_BEND = 4'hE;
    localparam logic [3:0] KIND_SYSTEM     = 4'hF;

    localparam logic [3:0] SYS_TIME_CODE   = 4'h1;
    localparam logic [3:0] SYS_SONG_POS    = 4'h2;
    localparam logic [3:0] SYS_SONG_SELECT = 4'h3;
    localparam logic [3:0] SYS_TUNE        = 4'h6;
    localparam logic [3:0] SYS_CLOCK       = 4'h8;
    localparam logic [3:0] SYS_START       = 4'hA;
    localparam logic [3:0] SYS_CONTINUE    = 4'hB;
    localparam logic [3:0] SYS_STOP        = 4'hC;
    localparam logic [3:0] SYS_SENSE       = 4'hE;
    localparam logic [3:0] SYS_META        = 4'hF;

    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [TICK_W-1:0]  delta;
        logic               msg_valid;
        logic [7:0]         status;
        logic [7:0]         byte_one;
        logic [7:0]         byte_two;
        logic [1:0]         length;
        logic               tempo_load;
        logic [TEMPO_W-1:0] tempo;
    } job_t;

endpackage

// ===== rtl/met_front.sv =====
module met_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [met_pkg::TICK_W-1:0]  event_ticks,
    input  logic [7:0]                  status_byte,
    input  logic [7:0]                  data_first,
    input  logic [7:0]                  data_second,
    input  logic [7:0]                  extra_first,
    input  logic [7:0]                  extra_second,
    input  logic [7:0]                  extra_third,
    input  logic [15:0]                 extra_count,
    output met_pkg::job_t               job
);
    import met_pkg::*;

    logic [TICK_W-1:0] prev_ticks_reg;
    logic [TICK_W-1:0] prev_ticks_next;
    logic [3:0]        kind;
    logic [3:0]        sys;
    logic [1:0]        len;
    logic [7:0]        b1;
    logic [7:0]        b2;
    logic              tempo_load;

    assign kind = status_byte[7:4];
    assign sys  = status_byte[3:0];

    always_comb
    begin
        len        = LEN_NONE;
        b1         = 8'd0;
        b2         = 8'd0;
        tempo_load = 1'b0;
        unique case (kind)
            KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESS, KIND_CONTROL, KIND_PITCH_BEND:
            begin
                len = LEN_THREE;
                b1  = data_first;
                b2  = data_second;
            end
            KIND_PROGRAM, KIND_CHAN_PRESS:
            begin
                len = LEN_TWO;
                b1  = data_first;
            end
            KIND_SYSTEM:
            begin
                unique case (sys)
                    SYS_TIME_CODE, SYS_SONG_SELECT:
                    begin
                        len = LEN_TWO;
                        b1  = extra_first;
                    end
                    SYS_SONG_POS:
                    begin
                        len = LEN_THREE;
                        b1  = extra_first;
                        b2  = extra_second;
                    end
                    SYS_TUNE, SYS_CLOCK, SYS_START, SYS_CONTINUE, SYS_STOP, SYS_SENSE:
                    begin
                        len = LEN_ONE;
                    end
                    SYS_META:
                    begin
                        tempo_load = (data_first == META_TEMPO) &&
                                     (extra_count >= TEMPO_MIN_EXTRA);
                    end
                    default:
                    begin
                        len = LEN_NONE;
                    end
                endcase
            end
            default:
            begin
                len = LEN_NONE;
            end
        endcase
    end

    always_comb
    begin
        job.delta      = event_ticks - prev_ticks_reg;
        job.msg_valid  = (len != LEN_NONE);
        job.status     = (len != LEN_NONE) ? status_byte : 8'd0;
        job.byte_one   = b1;
        job.byte_two   = b2;
        job.length     = len;
        job.tempo_load = tempo_load;
        job.tempo      = {extra_first, extra_second, extra_third};
    end

    assign prev_ticks_next = accept ? event_ticks : prev_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ticks_reg <= '0;
        end
        else
        begin
            prev_ticks_reg <= prev_ticks_next;
        end
    end

endmodule

// ===== rtl/met_queue.sv =====
module met_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  met_pkg::job_t wr_job,
    output logic          q_full,
    input  logic          rd_en,
    output met_pkg::job_t rd_job,
    output logic          q_empty
);
    import met_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/met_back.sv =====
module met_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [met_pkg::PPQ_W-1:0]     ppq,
    input  logic                          q_empty,
    input  met_pkg::job_t                 q_job,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic                          message_valid,
    output logic [7:0]                    message_status,
    output logic [7:0]                    message_byte_one,
    output logic [7:0]                    message_byte_two,
    output logic [1:0]                    message_length,
    output logic [met_pkg::TIME_W-1:0]    event_time_us
);
    import met_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    job_t               job_reg;
    logic [TEMPO_W-1:0] tempo_reg;
    logic [TEMPO_W-1:0] tempo_next;
    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  time_next;
    logic [PROD_W-1:0]  quo_reg;
    logic [PROD_W-1:0]  quo_next;
    logic [PPQ_W-1:0]   rem_reg;
    logic [PPQ_W-1:0]   rem_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PPQ_W:0]     rem_shift;
    logic               rem_ge;
    logic               commit;
    logic [TIME_W-1:0]  time_sum;

    logic               msg_valid_reg;
    logic [7:0]         msg_status_reg;
    logic [7:0]         msg_b1_reg;
    logic [7:0]         msg_b2_reg;
    logic [1:0]         msg_len_reg;
    logic [TIME_W-1:0]  trig_reg;

    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;
    assign commit = (state_reg == ST_DONE) && (!out_valid_reg || pop);

    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, ppq});

    // zero resolution adds no time
    assign time_sum = (ppq == '0) ? time_reg
                                  : time_reg + {{(TIME_W-PROD_W){1'b0}}, quo_reg};

    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        tempo_next = tempo_reg;
        time_next  = time_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                quo_next   = job_reg.delta * tempo_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[PROD_W-2:0], rem_ge};
                rem_next = rem_ge ? PPQ_W'(rem_shift - {1'b0, ppq})
                                  : rem_shift[PPQ_W-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    time_next  = time_sum;
                    tempo_next = job_reg.tempo_load ? job_reg.tempo : tempo_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (commit)
        begin
            msg_valid_reg  <= job_reg.msg_valid;
            msg_status_reg <= job_reg.status;
            msg_b1_reg     <= job_reg.byte_one;
            msg_b2_reg     <= job_reg.byte_two;
            msg_len_reg    <= job_reg.length;
            trig_reg       <= time_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tempo_reg     <= TEMPO_RESET;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tempo_reg     <= tempo_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty            = !out_valid_reg;
    assign message_valid    = msg_valid_reg;
    assign message_status   = msg_status_reg;
    assign message_byte_one = msg_b1_reg;
    assign message_byte_two = msg_b2_reg;
    assign message_length   = msg_len_reg;
    assign event_time_us    = trig_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed item not shown");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(trig_reg))
        else $error("waiting result lost or changed");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= CNT_LAST)
        else $error("divider count out of range");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && !q_empty |=> state_reg == ST_MUL)
        else $error("queued item not started");

    a_time_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(time_reg) && $stable(tempo_reg))
        else $error("running state changed without commit");

endmodule

// ===== rtl/midi_event_time_converter.sv =====
// midi event time converter
// input queue side: push with full; an item is taken when push is high and
// full is low. fields: event_ticks, status_byte, data and extra bytes.
// result queue side: empty with pop; the oldest result sits on the message
// and event_time_us ports while empty is low and leaves when pop is high.
// config: cfg_valid/cfg_ready write ticks_per_quarter; cfg_ready is always
// high; write it only while the block is idle.
// steps: a start state that takes the item from the queue, a multiply
// state, the bit-serial 56-step divide of delta*tempo by ticks_per_quarter
// and a commit state that waits until the result register is free.
// the back end works on one item at a time; a two-item queue in front lets
// up to two more items be pushed while one is in the divider.
// a stalled receiver holds the finished result; the divider then finishes
// the next item and waits, and full rises once the queue is used up.
// reset: tempo 500000 us per quarter, ticks_per_quarter 480, previous tick
// and running time zero, all queues empty.
module midi_event_time_converter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [met_pkg::TICK_W-1:0]  event_ticks,
    input  logic [7:0]                  status_byte,
    input  logic [7:0]                  data_first,
    input  logic [7:0]                  data_second,
    input  logic [7:0]                  extra_first,
    input  logic [7:0]                  extra_second,
    input  logic [7:0]                  extra_third,
    input  logic [15:0]                 extra_count,
    input  logic                        pop,
    output logic                        empty,
    output logic                        message_valid,
    output logic [7:0]                  message_status,
    output logic [7:0]                  message_byte_one,
    output logic [7:0]                  message_byte_two,
    output logic [1:0]                  message_length,
    output logic [met_pkg::TIME_W-1:0]  event_time_us,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [met_pkg::PPQ_W-1:0]   ticks_per_quarter
);
    import met_pkg::*;

    logic [PPQ_W-1:0] ppq_reg;
    logic [PPQ_W-1:0] ppq_next;
    logic             accept;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    job_t             front_job;
    job_t             head_job;

    assign cfg_ready = 1'b1;
    assign ppq_next  = (cfg_valid && cfg_ready) ? ticks_per_quarter : ppq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppq_reg <= PPQ_RESET;
        end
        else
        begin
            ppq_reg <= ppq_next;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    met_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .event_ticks  (event_ticks),
        .status_byte  (status_byte),
        .data_first   (data_first),
        .data_second  (data_second),
        .extra_first  (extra_first),
        .extra_second (extra_second),
        .extra_third  (extra_third),
        .extra_count  (extra_count),
        .job          (front_job)
    );

    met_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_job  (front_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty)
    );

    met_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .ppq              (ppq_reg),
        .q_empty          (q_empty),
        .q_job            (head_job),
        .q_pop            (q_pop),
        .pop              (pop),
        .empty            (empty),
        .message_valid    (message_valid),
        .message_status   (message_status),
        .message_byte_one (message_byte_one),
        .message_byte_two (message_byte_two),
        .message_length   (message_length),
        .event_time_us    (event_time_us)
    );

endmodule
